// ----- sv/tspfa_pkg.sv -----
// Package for the transport stream payload frame assembler.
// Widths, opcodes, result kinds, packet byte positions and the result record.
// No dependencies.
package tspfa_pkg;

  localparam int STORE_BYTES  = 131072;
  localparam int PACKET_BYTES = 188;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int LEN_W   = $clog2(STORE_BYTES + 1);
  localparam int CUT_W   = 16;
  localparam int CMP_W   = (LEN_W > CUT_W) ? LEN_W : CUT_W;
  localparam int RADDR_W = 17;
  localparam int FLEN_W  = 18;
  localparam int CNT_W   = 32;
  localparam int POS_W   = 8;
  localparam int REG_W   = 8;
  localparam int IDX_W   = 2;

  localparam logic [POS_W-1:0] POS_PID   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ID    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CTRL  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ADAPT = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CUT   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_START = POS_W'(23);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W:0]   ADAPT_BASE = (POS_W+1)'(5);

  localparam logic [7:0] PID_PLAIN = 8'h00;
  localparam logic [7:0] PID_START = 8'h40;
  localparam logic [1:0] CTRL_PAYLOAD = 2'd1;
  localparam logic [1:0] CTRL_ADAPT   = 2'd3;

  localparam logic [REG_W-1:0] MARKER_RESET = 8'h00;
  localparam logic [REG_W-1:0] PAYLOAD_RESET = 8'h11;
  localparam logic [REG_W-1:0] SCALE_RESET = 8'd92;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_EOS  = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_EOS   = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MARKER  = 2'd0,
    REG_PAYLOAD = 2'd1,
    REG_SCALE   = 2'd2
  } reg_idx_t;

  // One pending result between the update stage and the output register.
  typedef struct packed {
    kind_t              kind;
    logic               fvalid;
    logic [LEN_W-1:0]   src_len;
    logic [CUT_W-1:0]   cut;
    logic [CNT_W-1:0]   number;
    logic               ovf;
    logic               is_read;
    logic               in_range;
  } res_t;

endpackage

// ----- sv/tspfa_if.sv -----
// Handshake channels of the transport stream payload frame assembler.
// Input item, result item and configuration write channels; uses tspfa_pkg.
interface tspfa_item_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [7:0]                    data_byte;
  logic [tspfa_pkg::RADDR_W-1:0] read_addr;
  modport source (output valid, opcode, data_byte, read_addr, input ready);
  modport sink   (input valid, opcode, data_byte, read_addr, output ready);
endinterface

interface tspfa_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic                         frame_valid;
  logic [tspfa_pkg::FLEN_W-1:0] frame_length;
  logic [tspfa_pkg::CNT_W-1:0]  frame_number;
  logic                         short_flag;
  logic                         overflow_flag;
  logic [7:0]                   read_byte;
  modport source (output valid, result_kind, frame_valid, frame_length, frame_number,
                  short_flag, overflow_flag, read_byte, input ready);
  modport sink   (input valid, result_kind, frame_valid, frame_length, frame_number,
                  short_flag, overflow_flag, read_byte, output ready);
endinterface

interface tspfa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tspfa_pkg::IDX_W-1:0]  index;
  logic [tspfa_pkg::REG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ts_payload_frame_assembler.sv -----
// Transport stream payload frame assembler: top level, frame store and result path.
// Depends on tspfa_pkg and the channel interfaces in tspfa_if.sv.
//
//  channel  | role  | carries
//  ---------+-------+-----------------------------------------------------------
//  items    | sink  | opcode, data_byte, read_addr
//  results  | src   | result_kind, frame_valid, frame_length, frame_number,
//           |       | short_flag, overflow_flag, read_byte
//  cfg      | sink  | index, data (always ready)
//
// One item per cycle while results are taken. An item is decoded against the header
// registers in its accept cycle; a payload byte is written to the frame store that
// same edge. A result passes through s1, which waits for the registered store read
// port, and then the output register s2. Reset is synchronous; the store is not
// cleared and needs no sweep. A stalled results channel backs up into items.ready
// once the output register and the stage before it are both full.
module ts_payload_frame_assembler (
  input  logic                  clk,
  input  logic                  rst,
  tspfa_item_if.sink            items,
  tspfa_result_if.source        results,
  tspfa_cfg_if.sink             cfg
);

  // configuration
  logic [tspfa_pkg::REG_W-1:0] frame_marker_id;
  logic [tspfa_pkg::REG_W-1:0] payload_id;
  logic [tspfa_pkg::REG_W-1:0] tail_scale;

  // packet parse and frame state
  logic [tspfa_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]                  header_pid_byte, header_pid_byte_next;
  logic [7:0]                  header_id_byte, header_id_byte_next;
  logic [1:0]                  field_control, field_control_next;
  logic [7:0]                  adapt_length, adapt_length_next;
  logic [tspfa_pkg::LEN_W-1:0] collected_length, collected_length_next;
  logic [tspfa_pkg::CUT_W-1:0] tail_cut, tail_cut_next;
  logic [tspfa_pkg::CNT_W-1:0] frame_count, frame_count_next;
  logic                        frame_reported, frame_reported_next;
  logic                        overflow_seen, overflow_seen_next;

  // frame store
  logic [7:0]                   frame_store [tspfa_pkg::STORE_BYTES];
  logic [7:0]                   store_q;
  logic                         wr_en, rd_en;
  logic [tspfa_pkg::ADDR_W-1:0] wr_idx, rd_idx;
  logic [tspfa_pkg::ADDR_W+tspfa_pkg::RADDR_W-1:0] rd_ext;
  logic                         rd_in_range;

  // result path: s1 waits for store data, s2 is the output register
  tspfa_pkg::res_t res, s1;
  logic            res_valid, s1_valid, s1_adv;
  logic            s2_valid;
  logic [1:0]      s2_kind;
  logic            s2_fvalid, s2_short, s2_ovf;
  logic [tspfa_pkg::FLEN_W-1:0] s2_len;
  logic [tspfa_pkg::CNT_W-1:0]  s2_number;
  logic [7:0]      s2_byte;

  logic accept;
  logic take_byte, store_full;
  logic [tspfa_pkg::LEN_W-1:0] coll_after;
  logic ovf_after;
  logic [tspfa_pkg::POS_W:0] adapt_start;
  logic [tspfa_pkg::CMP_W-1:0] diff;
  logic short_now;

  assign s1_adv      = s1_valid && (!s2_valid || results.ready);
  assign items.ready = !s1_valid || s1_adv;
  assign accept      = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_marker_id <= tspfa_pkg::MARKER_RESET;
      payload_id      <= tspfa_pkg::PAYLOAD_RESET;
      tail_scale      <= tspfa_pkg::SCALE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tspfa_pkg::REG_MARKER:  frame_marker_id <= cfg.data;
        tspfa_pkg::REG_PAYLOAD: payload_id      <= cfg.data;
        tspfa_pkg::REG_SCALE:   tail_scale      <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---- payload byte selection for the current packet
  assign adapt_start = tspfa_pkg::ADAPT_BASE + (tspfa_pkg::POS_W+1)'(adapt_length);

  always_comb begin
    take_byte = 1'b0;
    if (byte_position >= tspfa_pkg::POS_ADAPT && header_id_byte == payload_id) begin
      if (field_control == tspfa_pkg::CTRL_PAYLOAD &&
          header_pid_byte == tspfa_pkg::PID_PLAIN) begin
        take_byte = 1'b1;
      end else if (field_control == tspfa_pkg::CTRL_PAYLOAD &&
                   header_pid_byte == tspfa_pkg::PID_START) begin
        take_byte = (byte_position >= tspfa_pkg::POS_START);
      end else if (field_control == tspfa_pkg::CTRL_ADAPT) begin
        take_byte = (byte_position != tspfa_pkg::POS_ADAPT) &&
                    ({1'b0, byte_position} >= adapt_start);
      end
    end
  end

  // Collection past the store capacity drops the byte and marks the frame.
  assign store_full = (collected_length >= tspfa_pkg::LEN_W'(tspfa_pkg::STORE_BYTES));
  assign coll_after = (take_byte && !store_full)
                      ? collected_length + tspfa_pkg::LEN_W'(1)
                      : collected_length;
  assign ovf_after  = overflow_seen || (take_byte && store_full);

  // ---- item decode and state update
  always_comb begin
    byte_position_next   = byte_position;
    header_pid_byte_next = header_pid_byte;
    header_id_byte_next  = header_id_byte;
    field_control_next   = field_control;
    adapt_length_next    = adapt_length;
    collected_length_next = collected_length;
    tail_cut_next        = tail_cut;
    frame_count_next     = frame_count;
    frame_reported_next  = frame_reported;
    overflow_seen_next   = overflow_seen;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    res_valid            = 1'b0;
    res.kind             = tspfa_pkg::KIND_EOS;
    res.fvalid           = 1'b0;
    res.src_len          = '0;
    res.cut              = '0;
    res.number           = frame_count;
    res.ovf              = 1'b0;
    res.is_read          = 1'b0;
    res.in_range         = rd_in_range;
    if (accept) begin
      case (items.opcode)
        tspfa_pkg::OP_READ: begin
          rd_en       = 1'b1;
          res_valid   = 1'b1;
          res.kind    = tspfa_pkg::KIND_READ;
          res.is_read = 1'b1;
        end
        tspfa_pkg::OP_EOS: begin
          // partial packet is dropped; any unreported frame rides on the report
          byte_position_next = '0;
          res_valid          = 1'b1;
          res.kind           = tspfa_pkg::KIND_EOS;
          if (!frame_reported) begin
            res.fvalid          = 1'b1;
            res.src_len         = collected_length;
            res.cut             = tail_cut;
            res.ovf             = overflow_seen;
            frame_reported_next = 1'b1;
          end
        end
        tspfa_pkg::OP_BYTE: begin
          byte_position_next = (byte_position >= tspfa_pkg::POS_LAST) ? '0
                               : byte_position + tspfa_pkg::POS_W'(1);
          if (byte_position == tspfa_pkg::POS_PID) begin
            header_pid_byte_next = items.data_byte;
          end else if (byte_position == tspfa_pkg::POS_ID) begin
            header_id_byte_next = items.data_byte;
            if (items.data_byte == frame_marker_id) begin
              // old frame goes out with the new count, then collection restarts
              frame_count_next = frame_count + tspfa_pkg::CNT_W'(1);
              if (!frame_reported) begin
                res_valid   = 1'b1;
                res.kind    = tspfa_pkg::KIND_FRAME;
                res.fvalid  = 1'b1;
                res.src_len = collected_length;
                res.cut     = tail_cut;
                res.ovf     = overflow_seen;
                res.number  = frame_count + tspfa_pkg::CNT_W'(1);
              end
              frame_reported_next   = 1'b0;
              collected_length_next = '0;
              overflow_seen_next    = 1'b0;
            end
          end else if (byte_position == tspfa_pkg::POS_CTRL) begin
            field_control_next = items.data_byte[5:4];
          end else if (byte_position >= tspfa_pkg::POS_ADAPT &&
                       header_id_byte == payload_id) begin
            wr_en                 = take_byte && !store_full;
            collected_length_next = coll_after;
            overflow_seen_next    = ovf_after;
            if (field_control == tspfa_pkg::CTRL_PAYLOAD &&
                header_pid_byte == tspfa_pkg::PID_START &&
                byte_position == tspfa_pkg::POS_CUT) begin
              tail_cut_next = tspfa_pkg::CUT_W'(items.data_byte) *
                              tspfa_pkg::CUT_W'(tail_scale);
            end else if (field_control == tspfa_pkg::CTRL_ADAPT) begin
              if (byte_position == tspfa_pkg::POS_ADAPT) begin
                adapt_length_next = items.data_byte;
              end
              // last byte of an adaptation packet closes the frame
              if (byte_position == tspfa_pkg::POS_LAST) begin
                res_valid           = 1'b1;
                res.kind            = tspfa_pkg::KIND_FRAME;
                res.fvalid          = 1'b1;
                res.src_len         = coll_after;
                res.cut             = tail_cut;
                res.ovf             = ovf_after;
                frame_reported_next = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      header_pid_byte  <= '0;
      header_id_byte   <= '0;
      field_control    <= '0;
      adapt_length     <= '0;
      collected_length <= '0;
      tail_cut         <= '0;
      frame_count      <= '0;
      frame_reported   <= 1'b1;
      overflow_seen    <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      header_pid_byte  <= header_pid_byte_next;
      header_id_byte   <= header_id_byte_next;
      field_control    <= field_control_next;
      adapt_length     <= adapt_length_next;
      collected_length <= collected_length_next;
      tail_cut         <= tail_cut_next;
      frame_count      <= frame_count_next;
      frame_reported   <= frame_reported_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

  // ---- frame store: one write port, one registered read port.
  // Reads and writes come from different items, so a read always sees
  // every earlier write; store_q only moves on a read, so it holds in a stall.
  assign wr_idx      = collected_length[tspfa_pkg::ADDR_W-1:0];
  assign rd_ext      = (tspfa_pkg::ADDR_W+tspfa_pkg::RADDR_W)'(items.read_addr);
  assign rd_idx      = rd_ext[tspfa_pkg::ADDR_W-1:0];
  assign rd_in_range = rd_ext < (tspfa_pkg::ADDR_W+tspfa_pkg::RADDR_W)'(tspfa_pkg::STORE_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_idx] <= items.data_byte;
    end
    if (rd_en) begin
      store_q <= frame_store[rd_idx];
    end
  end

  // ---- s1: result waiting for store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= res_valid;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= res;
    end
  end

  // length after the tail cut, clamped at zero
  assign short_now = tspfa_pkg::CMP_W'(s1.src_len) < tspfa_pkg::CMP_W'(s1.cut);
  assign diff      = tspfa_pkg::CMP_W'(s1.src_len) - tspfa_pkg::CMP_W'(s1.cut);

  // ---- s2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (results.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_kind   <= s1.kind;
      s2_fvalid <= s1.fvalid;
      s2_number <= s1.number;
      s2_ovf    <= s1.fvalid && s1.ovf;
      s2_short  <= s1.fvalid && short_now;
      s2_len    <= (s1.fvalid && !short_now) ? tspfa_pkg::FLEN_W'(diff) : '0;
      s2_byte   <= (s1.is_read && s1.in_range) ? store_q : 8'h00;
    end
  end

  assign results.valid         = s2_valid;
  assign results.result_kind   = s2_kind;
  assign results.frame_valid   = s2_fvalid;
  assign results.frame_length  = s2_len;
  assign results.frame_number  = s2_number;
  assign results.short_flag    = s2_short;
  assign results.overflow_flag = s2_ovf;
  assign results.read_byte     = s2_byte;

  // ---- checks
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !results.ready) |-> !items.ready)
    else $error("item taken with both result stages blocked");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    collected_length <= tspfa_pkg::LEN_W'(tspfa_pkg::STORE_BYTES))
    else $error("collected length beyond store capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= tspfa_pkg::POS_LAST)
    else $error("byte position beyond packet");

  a_marker_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && items.opcode == tspfa_pkg::OP_BYTE && byte_position == tspfa_pkg::POS_ID &&
     items.data_byte == frame_marker_id)
    |=> (collected_length == '0 && !frame_reported && !overflow_seen))
    else $error("marker packet did not restart collection");

  a_read_no_frame: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_kind == tspfa_pkg::KIND_READ) |-> (!s2_fvalid && s2_len == '0))
    else $error("read reply carries frame data");

endmodule
